/* rtl/pekf_pkg.sv */
package pekf_pkg;

	// State counts must stay at or below 8 entries, which nothing here enforces; three bits then cover every index.
	localparam int IDX_W = 3;
	localparam int CNT_W = 5;
	localparam int RED_STEPS = 3;
	localparam int DRAIN_CYCLES = 4;
	localparam int OUT_FIELDS = 12;
	localparam int EST_COUNT = 5;

	localparam logic [45:0] RED_MOD = 46'd6746518852;
	// floor(2^62 / RED_MOD)
	localparam logic [29:0] RED_RECIP = 30'd683565275;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	localparam logic [2:0] CFG_DEFAULT_STEP = 3'd0;
	localparam logic [2:0] CFG_MAX_STEP = 3'd1;
	localparam logic [2:0] CFG_INIT_VAR = 3'd2;
	localparam logic [2:0] CFG_NOISE_PX = 3'd3;
	localparam logic [2:0] CFG_NOISE_VY = 3'd7;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		SA_C, SA_S, SA_EST, SA_WZ, SA_AX, SA_NAY, SA_F, SA_FP
	} sel_a_t;

	typedef enum logic [2:0] {
		SB_AL, SB_AH, SB_DT, SB_P, SB_FT
	} sel_b_t;

	typedef enum logic [1:0] {
		BI_NONE, BI_EST, BI_NOISE
	} bias_t;

	typedef enum logic [2:0] {
		DST_AX, DST_AY, DST_EST, DST_F32, DST_F42, DST_FP, DST_P
	} dst_t;

	typedef struct packed {
		logic   valid;
		sel_a_t sel_a;
		sel_b_t sel_b;
		bias_t  bias;
		dst_t   dst;
		logic   neg;
		logic   first;
		logic   last;
		idx_t   i;
		idx_t   j;
		idx_t   k;
	} mac_cmd_t;

	typedef struct packed {
		logic             load;
		logic             init_we;
		logic             red_step;
		logic             fold;
		logic             rot_step;
		logic             out_load;
		logic [CNT_W-1:0] step;
		idx_t             i;
		idx_t             j;
		mac_cmd_t         mac;
	} dp_ctl_t;

	typedef struct packed {
		logic started;
	} dp_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_RED, ST_FOLD, ST_ROT, ST_ACC, ST_ACC_W,
		ST_EST, ST_EST_W, ST_FP, ST_FP_W, ST_PP, ST_PP_W, ST_OUT
	} ctrl_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = SAT_MAX;
		else if (v < -64'sd2147483648)
			r = SAT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// arctangent of 2^-n in Q2.30
	function automatic logic signed [35:0] atan_q30(input logic [CNT_W-1:0] n);
		logic signed [35:0] r;
		case (n)
			5'd0:  r = 36'sd843314856;
			5'd1:  r = 36'sd497837829;
			5'd2:  r = 36'sd263043836;
			5'd3:  r = 36'sd133525158;
			5'd4:  r = 36'sd67021686;
			5'd5:  r = 36'sd33543515;
			5'd6:  r = 36'sd16775850;
			5'd7:  r = 36'sd8388437;
			5'd8:  r = 36'sd4194282;
			5'd9:  r = 36'sd2097149;
			5'd10: r = 36'sd1048575;
			5'd11: r = 36'sd524287;
			5'd12: r = 36'sd262143;
			5'd13: r = 36'sd131071;
			5'd14: r = 36'sd65535;
			5'd15: r = 36'sd32767;
			5'd16: r = 36'sd16383;
			5'd17: r = 36'sd8191;
			5'd18: r = 36'sd4095;
			5'd19: r = 36'sd2047;
			5'd20: r = 36'sd1023;
			5'd21: r = 36'sd511;
			5'd22: r = 36'sd255;
			5'd23: r = 36'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/pekf_ctrl.sv */
module pekf_ctrl #(
	parameter int STATE_COUNT = 5,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  pekf_pkg::dp_sts_t  sts,
	output pekf_pkg::dp_ctl_t  ctl
);
	import pekf_pkg::*;

	localparam idx_t LAST = IDX_W'(STATE_COUNT - 1);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	idx_t             i_q, j_q, k_q;
	logic [2:0]       wait_q;
	logic             m_valid_q;
	logic             ijk_last, ij_last;

	assign ij_last = (i_q == LAST) && (j_q == LAST);
	assign ijk_last = ij_last && (k_q == LAST);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = sts.started ? ST_RED : ST_INIT;
			ST_INIT:  if (ij_last) state_d = ST_RED;
			ST_RED:   if (cnt_q == '0) state_d = ST_FOLD;
			ST_FOLD:  state_d = ST_ROT;
			ST_ROT:   if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_ACC;
			ST_ACC:   if (cnt_q == CNT_W'(3)) state_d = ST_ACC_W;
			ST_ACC_W: if (wait_q == '0) state_d = ST_EST;
			ST_EST:   if (cnt_q == CNT_W'(6)) state_d = ST_EST_W;
			ST_EST_W: if (wait_q == '0) state_d = ST_FP;
			ST_FP:    if (ijk_last) state_d = ST_FP_W;
			ST_FP_W:  if (wait_q == '0) state_d = ST_PP;
			ST_PP:    if (ijk_last) state_d = ST_PP_W;
			ST_PP_W:  if (wait_q == '0) state_d = ST_OUT;
			ST_OUT:   if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.step = cnt_q;
		ctl.i = i_q;
		ctl.j = j_q;
		ctl.mac.i = i_q;
		ctl.mac.j = j_q;
		ctl.mac.k = k_q;
		ctl.mac.sel_a = SA_C;
		ctl.mac.sel_b = SB_AL;
		ctl.mac.bias = BI_NONE;
		ctl.mac.dst = DST_AX;
		unique case (state_q)
			ST_IDLE: ctl.load = s_tvalid;
			ST_INIT: ctl.init_we = 1'b1;
			ST_RED:  ctl.red_step = 1'b1;
			ST_FOLD: ctl.fold = 1'b1;
			ST_ROT:  ctl.rot_step = 1'b1;
			ST_ACC: begin
				ctl.mac.valid = 1'b1;
				ctl.mac.first = ~cnt_q[0];
				ctl.mac.last = cnt_q[0];
				case (cnt_q[1:0])
					2'd0: begin
						ctl.mac.sel_a = SA_C;
						ctl.mac.sel_b = SB_AL;
					end
					2'd1: begin
						ctl.mac.sel_a = SA_S;
						ctl.mac.sel_b = SB_AH;
						ctl.mac.neg = 1'b1;
						ctl.mac.dst = DST_AX;
					end
					2'd2: begin
						ctl.mac.sel_a = SA_S;
						ctl.mac.sel_b = SB_AL;
					end
					default: begin
						ctl.mac.sel_a = SA_C;
						ctl.mac.sel_b = SB_AH;
						ctl.mac.dst = DST_AY;
					end
				endcase
			end
			ST_EST: begin
				ctl.mac.valid = 1'b1;
				ctl.mac.first = 1'b1;
				ctl.mac.last = 1'b1;
				ctl.mac.sel_b = SB_DT;
				ctl.mac.bias = BI_EST;
				ctl.mac.dst = DST_EST;
				ctl.mac.i = cnt_q[IDX_W-1:0];
				case (cnt_q[2:0])
					3'd0: begin
						ctl.mac.sel_a = SA_EST;
						ctl.mac.k = IDX_W'(3);
					end
					3'd1: begin
						ctl.mac.sel_a = SA_EST;
						ctl.mac.k = IDX_W'(4);
					end
					3'd2: ctl.mac.sel_a = SA_WZ;
					3'd3: ctl.mac.sel_a = SA_AX;
					3'd4: ctl.mac.sel_a = SA_NAY;
					3'd5: begin
						// F(vx, heading) = -ay * dt
						ctl.mac.sel_a = SA_NAY;
						ctl.mac.bias = BI_NONE;
						ctl.mac.dst = DST_F32;
					end
					default: begin
						ctl.mac.sel_a = SA_AX;
						ctl.mac.bias = BI_NONE;
						ctl.mac.dst = DST_F42;
					end
				endcase
				// ay enters the vy update unnegated
				if (cnt_q[2:0] == 3'd4)
					ctl.mac.neg = 1'b0;
			end
			ST_FP: begin
				ctl.mac.valid = 1'b1;
				ctl.mac.first = (k_q == '0);
				ctl.mac.last = (k_q == LAST);
				ctl.mac.sel_a = SA_F;
				ctl.mac.sel_b = SB_P;
				ctl.mac.dst = DST_FP;
			end
			ST_PP: begin
				ctl.mac.valid = 1'b1;
				ctl.mac.first = (k_q == '0);
				ctl.mac.last = (k_q == LAST);
				ctl.mac.sel_a = SA_FP;
				ctl.mac.sel_b = SB_FT;
				ctl.mac.bias = BI_NOISE;
				ctl.mac.dst = DST_P;
			end
			ST_OUT: ctl.out_load = !m_valid_q || m_tready;
			default: ctl.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			wait_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			if (ctl.out_load)
				m_valid_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= CNT_W'(RED_STEPS - 1);
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				ST_INIT: begin
					if (j_q == LAST) begin
						j_q <= '0;
						i_q <= ij_last ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RED:  cnt_q <= cnt_q - 1'b1;
				ST_FOLD: cnt_q <= '0;
				ST_ROT:  cnt_q <= (cnt_q == CNT_W'(CORDIC_STEPS - 1)) ? '0 : cnt_q + 1'b1;
				ST_ACC, ST_EST: begin
					cnt_q <= cnt_q + 1'b1;
					wait_q <= 3'(DRAIN_CYCLES - 1);
				end
				ST_ACC_W: begin
					wait_q <= wait_q - 1'b1;
					cnt_q <= '0;
				end
				ST_FP, ST_PP: begin
					wait_q <= 3'(DRAIN_CYCLES - 1);
					if (k_q == LAST) begin
						k_q <= '0;
						if (j_q == LAST) begin
							j_q <= '0;
							i_q <= (i_q == LAST) ? '0 : i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_EST_W, ST_FP_W, ST_PP_W: wait_q <= wait_q - 1'b1;
				default: wait_q <= wait_q;
			endcase
		end
	end

endmodule

/* rtl/pekf_dp.sv */
module pekf_dp #(
	parameter int STATE_COUNT = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [31:0]         sample_time,
	input  logic signed [31:0]  accel_long,
	input  logic signed [31:0]  accel_lat,
	input  logic signed [31:0]  yaw_rate,
	input  pekf_pkg::dp_ctl_t   ctl,
	output pekf_pkg::dp_sts_t   sts,
	output logic [pekf_pkg::OUT_FIELDS*32-1:0] res
);
	import pekf_pkg::*;

	localparam int MEM_DEPTH = STATE_COUNT * STATE_COUNT;
	localparam int AW = $clog2(MEM_DEPTH);

	function automatic logic [AW-1:0] addr_of(input idx_t r, input idx_t c);
		return AW'(int'(r) * STATE_COUNT + int'(c));
	endfunction

	function automatic logic signed [31:0] f_val(input idx_t r, input idx_t c,
			input logic signed [31:0] dt, input logic signed [31:0] f32,
			input logic signed [31:0] f42);
		logic signed [31:0] v;
		if (r == c)
			v = ONE_Q16;
		else if ((r == IDX_W'(0) && c == IDX_W'(3)) || (r == IDX_W'(1) && c == IDX_W'(4)))
			v = dt;
		else if (r == IDX_W'(3) && c == IDX_W'(2))
			v = f32;
		else if (r == IDX_W'(4) && c == IDX_W'(2))
			v = f42;
		else
			v = '0;
		return v;
	endfunction

	// configuration
	logic [15:0] def_step_q, max_step_q;
	logic [31:0] init_var_q;
	logic [31:0] noise_q [EST_COUNT];

	// per-item state
	logic [31:0]        prev_q;
	logic               started_q;
	logic signed [31:0] al_q, ah_q, wz_q, dt_q;
	logic signed [31:0] est_q [EST_COUNT];
	logic signed [31:0] ax_q, ay_q, f32_q, f42_q;
	logic signed [31:0] diag_q [EST_COUNT];
	logic [OUT_FIELDS*32-1:0] res_q;

	// sine/cosine unit
	logic               sign_q, flip_q;
	logic [45:0]        mag_q;
	logic [12:0]        quo_q;
	logic signed [35:0] x_q, y_q, z_q;

	logic signed [32:0] d_w;
	logic signed [31:0] iv_w;
	logic signed [45:0] ang_w;
	logic [61:0]        rp_w;
	logic [45:0]        qm_w;
	logic signed [35:0] z0_w, z1_w, z2_w, xf_w, yf_w, sx_w, sy_w, at_w;
	logic               flip_w;
	logic signed [31:0] c_w, s_w, nay_w;

	// multiply-accumulate pipeline
	logic signed [31:0] p_mem  [MEM_DEPTH];
	logic signed [31:0] fp_mem [MEM_DEPTH];
	mac_cmd_t           cmd_s1, cmd_s2, cmd_s3;
	logic signed [31:0] p_rd_s1, fp_rd_s1;
	logic signed [31:0] a_w, b_w, a_s2, b_s2;
	logic signed [63:0] prod_s3;
	logic signed [63:0] rnd_w;
	logic signed [31:0] m_w, term_w, res_w;
	logic signed [39:0] bias_w, sum_w, acc_q;
	logic               wr_w;

	assign sts.started = started_q;
	assign res = res_q;

	assign d_w = $signed({1'b0, sample_time}) - $signed({1'b0, prev_q});
	assign iv_w = init_var_q[31] ? SAT_MAX : $signed(init_var_q);
	assign ang_w = {{14{est_q[2][31]}}, est_q[2]} <<< 14;
	// quotient estimate by 2*pi from the reciprocal; at most one low
	assign rp_w = 62'(mag_q[45:14]) * 62'(RED_RECIP);
	assign qm_w = 46'(quo_q) * RED_MOD;

	always_comb begin
		z0_w = $signed({3'b000, mag_q[32:0]});
		if (sign_q)
			z0_w = -z0_w;
		z1_w = z0_w;
		if (z0_w > PI_Q30)
			z1_w = z0_w - TWO_PI_Q30;
		else if (z0_w < -PI_Q30)
			z1_w = z0_w + TWO_PI_Q30;
		z2_w = z1_w;
		flip_w = 1'b0;
		if (z1_w > HALF_PI_Q30) begin
			z2_w = z1_w - PI_Q30;
			flip_w = 1'b1;
		end else if (z1_w < -HALF_PI_Q30) begin
			z2_w = z1_w + PI_Q30;
			flip_w = 1'b1;
		end
	end

	assign sx_w = x_q >>> ctl.step;
	assign sy_w = y_q >>> ctl.step;
	assign at_w = atan_q30(ctl.step);
	assign xf_w = flip_q ? -x_q : x_q;
	assign yf_w = flip_q ? -y_q : y_q;
	assign c_w = sat32((64'(xf_w) + 64'sd8192) >>> 14);
	assign s_w = sat32((64'(yf_w) + 64'sd8192) >>> 14);
	assign nay_w = (ay_q == SAT_MIN) ? SAT_MAX : -ay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_step_q <= 16'd655;
			max_step_q <= 16'd6554;
			init_var_q <= 32'd65536;
			for (int n = 0; n < EST_COUNT; n++)
				noise_q[n] <= 32'd655;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				CFG_DEFAULT_STEP: def_step_q <= cfg_data[15:0];
				CFG_MAX_STEP:     max_step_q <= cfg_data[15:0];
				CFG_INIT_VAR:     init_var_q <= cfg_data;
				[CFG_NOISE_PX:CFG_NOISE_VY]: noise_q[cfg_index - CFG_NOISE_PX] <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			started_q <= 1'b0;
			for (int n = 0; n < EST_COUNT; n++)
				est_q[n] <= '0;
		end else begin
			if (ctl.load) begin
				prev_q <= sample_time;
				started_q <= 1'b1;
			end
			if (wr_w && cmd_s3.dst == DST_EST)
				est_q[cmd_s3.i] <= res_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			al_q <= accel_long;
			ah_q <= accel_lat;
			wz_q <= yaw_rate;
			if (d_w <= 0 || d_w > $signed({17'b0, max_step_q}))
				dt_q <= {16'b0, def_step_q};
			else
				dt_q <= d_w[31:0];
			sign_q <= ang_w[45];
			mag_q <= ang_w[45] ? 46'(-ang_w) : 46'(ang_w);
		end
		// remainder by 2*pi: estimate, multiply back, one correction
		if (ctl.red_step) begin
			case (ctl.step)
				5'd2: quo_q <= rp_w[60:48];
				5'd1: mag_q <= mag_q - qm_w;
				default: begin
					if (mag_q >= RED_MOD)
						mag_q <= mag_q - RED_MOD;
				end
			endcase
		end
		if (ctl.fold) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z2_w;
			flip_q <= flip_w;
		end
		if (ctl.rot_step) begin
			if (z_q >= 0) begin
				x_q <= x_q - sy_w;
				y_q <= y_q + sx_w;
				z_q <= z_q - at_w;
			end else begin
				x_q <= x_q + sy_w;
				y_q <= y_q - sx_w;
				z_q <= z_q + at_w;
			end
		end
		if (ctl.out_load) begin
			for (int n = 0; n < EST_COUNT; n++) begin
				res_q[n*32 +: 32] <= est_q[n];
				res_q[(n + 7)*32 +: 32] <= diag_q[n];
			end
			res_q[5*32 +: 32] <= ax_q;
			res_q[6*32 +: 32] <= ay_q;
		end
	end

	// stage 1: memory read data registered with the request
	always_ff @(posedge clk) begin
		if (ctl.init_we)
			p_mem[addr_of(ctl.i, ctl.j)] <= (ctl.i == ctl.j) ? iv_w : '0;
		else if (wr_w && cmd_s3.dst == DST_P)
			p_mem[addr_of(cmd_s3.i, cmd_s3.j)] <= res_w;
		p_rd_s1 <= p_mem[addr_of(ctl.mac.k, ctl.mac.j)];
	end

	always_ff @(posedge clk) begin
		if (wr_w && cmd_s3.dst == DST_FP)
			fp_mem[addr_of(cmd_s3.i, cmd_s3.j)] <= res_w;
		fp_rd_s1 <= fp_mem[addr_of(ctl.mac.i, ctl.mac.k)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
			cmd_s3 <= '0;
		end else begin
			cmd_s1 <= ctl.mac;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
		end
	end

	// stage 2: operand select
	always_comb begin
		case (cmd_s1.sel_a)
			SA_C:    a_w = c_w;
			SA_S:    a_w = s_w;
			SA_EST:  a_w = est_q[cmd_s1.k];
			SA_WZ:   a_w = wz_q;
			SA_AX:   a_w = ax_q;
			SA_NAY:  a_w = (cmd_s1.dst == DST_F32) ? nay_w : ay_q;
			SA_F:    a_w = f_val(cmd_s1.i, cmd_s1.k, dt_q, f32_q, f42_q);
			default: a_w = fp_rd_s1;
		endcase
		case (cmd_s1.sel_b)
			SB_AL:   b_w = al_q;
			SB_AH:   b_w = ah_q;
			SB_DT:   b_w = dt_q;
			SB_P:    b_w = p_rd_s1;
			default: b_w = f_val(cmd_s1.j, cmd_s1.k, dt_q, f32_q, f42_q);
		endcase
	end

	always_ff @(posedge clk) begin
		a_s2 <= a_w;
		b_s2 <= b_w;
		prod_s3 <= 64'(a_s2) * 64'(b_s2);
	end

	// stage 4: round, saturate, accumulate, write back
	assign rnd_w = (prod_s3 + 64'sd32768) >>> 16;
	assign m_w = sat32(rnd_w);
	assign term_w = (cmd_s3.neg && m_w == SAT_MIN) ? SAT_MAX :
		(cmd_s3.neg ? -m_w : m_w);

	always_comb begin
		case (cmd_s3.bias)
			BI_EST:  bias_w = 40'(est_q[cmd_s3.i]);
			BI_NOISE: begin
				if (cmd_s3.i == cmd_s3.j && cmd_s3.i < IDX_W'(EST_COUNT))
					bias_w = $signed({8'b0, noise_q[cmd_s3.i]});
				else
					bias_w = '0;
			end
			default: bias_w = '0;
		endcase
	end

	assign sum_w = (cmd_s3.first ? bias_w : acc_q) + 40'(term_w);
	assign res_w = sat32(64'(sum_w));
	assign wr_w = cmd_s3.valid && cmd_s3.last;

	always_ff @(posedge clk) begin
		if (cmd_s3.valid)
			acc_q <= sum_w;
		if (wr_w) begin
			case (cmd_s3.dst)
				DST_AX:  ax_q <= res_w;
				DST_AY:  ay_q <= res_w;
				DST_F32: f32_q <= res_w;
				DST_F42: f42_q <= res_w;
				DST_P: begin
					if (cmd_s3.i == cmd_s3.j && cmd_s3.i < IDX_W'(EST_COUNT))
						diag_q[cmd_s3.i] <= res_w;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/planar_ins_ekf_predict.sv */
// channel  direction  handshake               payload
// s        in         s_tvalid/s_tready       sample
// m        out        m_tvalid/m_tready       estimate, world accel, variances
// cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each request runs from accept to the next ready through the single shared
// multiply-accumulate pipeline; the first request after reset also loads the
// covariance.
// Reset clears the estimate, the previous timestamp and all control state.
// A result waiting on m does not block the next request; the block stalls
// only at the end of a request if the previous result is still held.
module planar_ins_ekf_predict #(
	parameter int STATE_COUNT = 5,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample_time, accel_long, accel_lat, yaw_rate
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, heading, vel_x, vel_y, accel_x, accel_y,
	// var_x, var_y, var_heading, var_vel_x, var_vel_y
	output logic [383:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import pekf_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	pekf_ctrl #(
		.STATE_COUNT(STATE_COUNT),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.ctl(ctl)
	);

	pekf_dp #(
		.STATE_COUNT(STATE_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_time(s_tdata[31:0]),
		.accel_long($signed(s_tdata[63:32])),
		.accel_lat($signed(s_tdata[95:64])),
		.yaw_rate($signed(s_tdata[127:96])),
		.ctl(ctl),
		.sts(sts),
		.res(m_tdata)
	);

endmodule
